@@ rtl/spd_pkg.sv @@
`default_nettype none
package spd_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        range_mm;
        logic signed [15:0] azimuth;
        logic signed [15:0] elevation;
        logic               invalid;
        logic signed [15:0] red_in;
        logic signed [15:0] green_in;
        logic signed [15:0] blue_in;
        logic [15:0]        intensity;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] x_offset;
        logic signed [31:0] y_offset;
        logic signed [31:0] z_offset;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_out_item;

    localparam logic [2:0] REG_SCAN_FORMAT  = 3'd0;
    localparam logic [2:0] REG_PALETTE_SLOT = 3'd1;
    localparam logic [2:0] REG_KEEP_STRIDE  = 3'd2;
    localparam logic [2:0] REG_INT_LOW      = 3'd3;
    localparam logic [2:0] REG_INT_HIGH     = 3'd4;
    localparam logic [2:0] REG_ORIGIN_X     = 3'd5;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd6;
    localparam logic [2:0] REG_ORIGIN_Z     = 3'd7;

    localparam logic [1:0] COL_RGB     = 2'd0;
    localparam logic [1:0] COL_GREY    = 2'd1;
    localparam logic [1:0] COL_PALETTE = 2'd2;

    localparam logic signed [35:0] CORDIC_X0 = 36'sd652032874;

    typedef enum logic [3:0] {
        S_IDLE, S_AZ, S_EL, S_DIV, S_MUL_T, S_MUL_X, S_MUL_Y, S_MUL_Z, S_OFFS
    } t_state;

    // cordic unit control
    typedef struct packed {
        logic        start;
        logic [15:0] angle;
    } t_cordic_ctl;

    function automatic logic [31:0] atan_unit(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912; 5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907; 5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;  5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;  5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;   5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
            5'd20: v = 32'd652;       5'd21: v = 32'd326;
            5'd22: v = 32'd163;       5'd23: v = 32'd81;
            5'd24: v = 32'd41;        5'd25: v = 32'd20;
            5'd26: v = 32'd10;        5'd27: v = 32'd5;
            5'd28: v = 32'd3;         5'd29: v = 32'd1;
            5'd30: v = 32'd1;         default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [23:0] hue(input logic [3:0] k);
        logic [23:0] v;
        case (k[2:0])
            3'd0: v = {8'd140, 8'd199, 8'd255};
            3'd1: v = {8'd255, 8'd199, 8'd115};
            3'd2: v = {8'd158, 8'd230, 8'd158};
            3'd3: v = {8'd240, 8'd168, 8'd219};
            3'd4: v = {8'd250, 8'd235, 8'd140};
            3'd5: v = {8'd179, 8'd179, 8'd242};
            3'd6: v = {8'd140, 8'd235, 8'd230};
            default: v = {8'd235, 8'd153, 8'd140};
        endcase
        return v;
    endfunction

    function automatic logic [7:0] clamp_byte(input logic signed [15:0] v);
        logic [7:0] r;
        if (v < 0) r = 8'd0;
        else if (v > 16'sd255) r = 8'd255;
        else r = v[7:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/spd_cordic.sv @@
`default_nettype none
module spd_cordic
    import spd_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_cordic_ctl       i_ctl,
    output logic              o_done,
    output logic signed [35:0] o_cos,
    output logic signed [35:0] o_sin
);
    localparam int NS = (STEPS > 32) ? 32 : STEPS;

    logic signed [35:0] r_x, r_y, n_x, n_y;
    logic signed [34:0] r_a, n_a;
    logic [5:0]         r_i;
    logic               r_busy, r_neg;
    logic signed [34:0] a0;
    logic signed [34:0] a_init;
    logic               neg_init;
    logic signed [34:0] at;

    assign at = 35'($signed({1'b0, atan_unit(r_i[4:0])}));

    always_comb begin
        a0 = 35'($signed(i_ctl.angle)) <<< 16;
        // fold angles beyond a quarter turn back by half a turn
        a_init = a0;
        neg_init = 1'b0;
        if (a0 > (35'sd1 <<< 30)) begin
            a_init = a0 - (35'sd1 <<< 31);
            neg_init = 1'b1;
        end else if (a0 < -(35'sd1 <<< 30)) begin
            a_init = a0 + (35'sd1 <<< 31);
            neg_init = 1'b1;
        end
        n_x = r_x;
        n_y = r_y;
        n_a = r_a;
        if (r_a >= 0) begin
            n_x = r_x - (r_y >>> r_i);
            n_y = r_y + (r_x >>> r_i);
            n_a = r_a - at;
        end else begin
            n_x = r_x + (r_y >>> r_i);
            n_y = r_y - (r_x >>> r_i);
            n_a = r_a + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                o_done <= 1'b0;
                r_i    <= '0;
                r_x    <= CORDIC_X0;
                r_y    <= '0;
                r_neg  <= neg_init;
                r_a    <= a_init;
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_a <= n_a;
                r_i <= r_i + 6'd1;
                o_done <= (r_i == 6'(NS - 1));
                if (r_i == 6'(NS - 1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                o_done <= 1'b0;
            end
        end
    end

    assign o_cos = r_neg ? -r_x : r_x;
    assign o_sin = r_neg ? -r_y : r_y;
endmodule
`default_nettype wire

@@ rtl/scan_point_decode_top.sv @@
`default_nettype none
// Scan point decoder. One item is taken at a time; o_stall on the input is
// high while an item is in work, and a finished result waits in the output
// register so the next item can start. A dropped item (skipped by the stride
// or marked invalid) never leaves the idle state. A kept cartesian item
// passes the divide and offset steps. A spherical item runs azimuth and then
// elevation through the shared CORDIC rotator, then 4 multiply steps, each
// over a low and a high operand slice (a 19x32-bit partial product per
// cycle), before the same divide and offset steps. Grey intensity uses a
// restoring divider in the divide step that produces the 8 quotient bits. The
// offset step holds while the previous result is still stalled on the output.
module scan_point_decode_top
    import spd_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int PALETTE_ENTRIES = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  t_in_item   i_data,
    output logic       o_valid,
    input  wire        i_stall,
    output t_out_item  o_data,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_idx,
    input  wire [31:0] i_cfg_data
);
    localparam int NPAL = (PALETTE_ENTRIES > 0) ? PALETTE_ENTRIES : 1;

    logic [2:0]  r_fmt, r_pal;
    logic [31:0] r_stride, r_phase;
    logic [15:0] r_lo, r_hi;
    logic signed [31:0] r_ox, r_oy, r_oz;

    t_state r_st, n_st;
    t_in_item r_in;
    logic [1:0] r_mode;
    logic signed [35:0] r_ca, r_sa, r_ce, r_se;
    logic signed [63:0] r_x, r_y, r_z, r_t;
    logic [15:0] r_rem, r_den;
    logic [23:0] r_num;
    logic [7:0]  r_q;
    logic [3:0]  r_dcnt;
    logic        r_ov;
    logic        r_half;
    logic signed [50:0] r_pp;
    logic        r_ovalid;
    t_out_item   r_out;

    t_cordic_ctl cctl;
    logic        cdone;
    logic signed [35:0] ccos, csin;

    spd_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(cctl),
        .o_done(cdone), .o_cos(ccos), .o_sin(csin)
    );

    logic accept, keep, sph, out_load;
    logic [31:0] stride;
    logic [2:0]  fmt;
    logic [1:0]  fmt_mode;
    logic [23:0] num_in;
    assign accept = i_valid && !o_stall;
    assign o_stall = (r_st != S_IDLE);
    assign stride = (r_stride == 32'd0) ? 32'd1 : r_stride;
    assign fmt = (r_fmt > 3'd5) ? 3'd5 : r_fmt;
    assign keep = (r_phase == 32'd0) && !i_data.invalid;
    assign sph = (fmt >= 3'd3);
    assign fmt_mode = sph ? 2'(fmt - 3'd3) : fmt[1:0];
    assign num_in = 24'd215 * {8'd0, 16'(i_data.intensity - r_lo)};
    assign out_load = (r_st == S_OFFS) && (!r_ovalid || !i_stall);

    // shared multiplier: 36-bit signed operand times Q30 value, low slice of the
    // operand first, then the high slice
    logic signed [35:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [18:0] mul_h;
    logic signed [50:0] mul_pp;
    logic signed [71:0] mul_sum;
    logic signed [63:0] mul_r;
    always_comb begin
        mul_a = '0; mul_b = '0;
        unique case (r_st)
            S_MUL_T: begin
                mul_a = $signed({4'd0, r_in.range_mm}); mul_b = $signed(r_ce[31:0]);
            end
            S_MUL_X: begin mul_a = $signed(r_t[35:0]); mul_b = $signed(r_ca[31:0]); end
            S_MUL_Y: begin mul_a = $signed(r_t[35:0]); mul_b = $signed(r_sa[31:0]); end
            S_MUL_Z: begin
                mul_a = $signed({4'd0, r_in.range_mm}); mul_b = $signed(r_se[31:0]);
            end
            default: ;
        endcase
        if (r_half) mul_h = 19'($signed(mul_a[35:18]));
        else mul_h = $signed({1'b0, mul_a[17:0]});
        mul_pp = 51'(mul_h * mul_b);
        mul_sum = (72'(mul_pp) <<< 18) + 72'(r_pp) + (72'sd1 <<< 29);
        mul_r = 64'(mul_sum >>> 30);
    end

    logic [16:0] dtry;
    assign dtry = {r_rem, r_num[23]} - {1'b0, r_den};

    logic [2:0]  pal_k;
    logic [23:0] pal_col;
    always_comb begin
        pal_k = '0;
        for (int j = 0; j < 8; j++)
            if (r_pal == 3'(j)) pal_k = 3'(j % NPAL);
    end
    assign pal_col = hue({1'b0, pal_k});

    function automatic logic signed [31:0] sat(input logic signed [63:0] v,
                                               input logic signed [31:0] o);
        logic signed [64:0] d;
        logic signed [31:0] r;
        d = 65'(v) - 65'(o);
        if (d > 65'sd2147483647) r = 32'h7fffffff;
        else if (d < -65'sd2147483648) r = 32'h80000000;
        else r = d[31:0];
        return r;
    endfunction

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (accept && keep) n_st = sph ? S_AZ : S_DIV;
            S_AZ:    if (cdone) n_st = S_EL;
            S_EL:    if (cdone) n_st = S_MUL_T;
            S_MUL_T: if (r_half) n_st = S_MUL_X;
            S_MUL_X: if (r_half) n_st = S_MUL_Y;
            S_MUL_Y: if (r_half) n_st = S_MUL_Z;
            S_MUL_Z: if (r_half) n_st = S_DIV;
            S_DIV:   if (r_mode != COL_GREY || r_dcnt == 4'd8) n_st = S_OFFS;
            S_OFFS:  if (!r_ovalid || !i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        cctl.start = 1'b0;
        cctl.angle = r_in.azimuth;
        if (r_st == S_IDLE && accept && keep && sph) begin
            cctl.start = 1'b1;
            cctl.angle = i_data.azimuth;
        end else if (r_st == S_AZ && cdone) begin
            cctl.start = 1'b1;
            cctl.angle = r_in.elevation;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= 3'd2; r_pal <= '0; r_stride <= 32'd1;
            r_lo <= '0; r_hi <= 16'hffff;
            r_ox <= '0; r_oy <= '0; r_oz <= '0;
            r_phase <= '0;
            r_st <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (out_load) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SCAN_FORMAT:  r_fmt <= i_cfg_data[2:0];
                    REG_PALETTE_SLOT: r_pal <= i_cfg_data[2:0];
                    REG_KEEP_STRIDE:  r_stride <= i_cfg_data;
                    REG_INT_LOW:      r_lo <= i_cfg_data[15:0];
                    REG_INT_HIGH:     r_hi <= i_cfg_data[15:0];
                    REG_ORIGIN_X:     r_ox <= i_cfg_data;
                    REG_ORIGIN_Y:     r_oy <= i_cfg_data;
                    REG_ORIGIN_Z:     r_oz <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept)
                r_phase <= (r_phase >= stride - 32'd1) ? 32'd0 : r_phase + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: if (accept) begin
                r_in <= i_data;
                r_x <= 64'(i_data.pos_x);
                r_y <= 64'(i_data.pos_y);
                r_z <= 64'(i_data.pos_z);
                r_half <= 1'b0;
                r_dcnt <= '0;
                // quotient fits 8 bits: start from the top 16 dividend bits
                r_rem <= num_in[23:8];
                r_num <= {num_in[7:0], 16'd0};
                r_q <= '0;
                r_den <= r_hi - r_lo;
                r_mode <= (fmt_mode == COL_GREY && r_hi <= r_lo) ? COL_PALETTE : fmt_mode;
                r_ov <= (i_data.intensity <= r_lo) || (i_data.intensity >= r_hi);
            end
            S_AZ: if (cdone) begin r_ca <= ccos; r_sa <= csin; end
            S_EL: if (cdone) begin r_ce <= ccos; r_se <= csin; end
            S_MUL_T: begin
                r_pp <= mul_pp; r_half <= !r_half;
                if (r_half) r_t <= mul_r;
            end
            S_MUL_X: begin
                r_pp <= mul_pp; r_half <= !r_half;
                if (r_half) r_x <= mul_r;
            end
            S_MUL_Y: begin
                r_pp <= mul_pp; r_half <= !r_half;
                if (r_half) r_y <= mul_r;
            end
            S_MUL_Z: begin
                r_pp <= mul_pp; r_half <= !r_half;
                if (r_half) r_z <= mul_r;
            end
            S_DIV: begin
                if (r_mode == COL_GREY && r_dcnt != 4'd8) begin
                    // restoring division, one quotient bit a cycle
                    r_num <= {r_num[22:0], 1'b0};
                    r_dcnt <= r_dcnt + 4'd1;
                    if (!dtry[16]) begin
                        r_rem <= dtry[15:0]; r_q <= {r_q[6:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[14:0], r_num[23]}; r_q <= {r_q[6:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out.x_offset <= sat(r_x, r_ox);
            r_out.y_offset <= sat(r_y, r_oy);
            r_out.z_offset <= sat(r_z, r_oz);
            unique case (r_mode)
                COL_RGB: begin
                    r_out.red <= clamp_byte(r_in.red_in);
                    r_out.green <= clamp_byte(r_in.green_in);
                    r_out.blue <= clamp_byte(r_in.blue_in);
                end
                COL_GREY: begin
                    r_out.red   <= r_ov ? ((r_in.intensity <= r_lo) ? 8'd40 : 8'd255)
                                        : 8'd40 + r_q;
                    r_out.green <= r_ov ? ((r_in.intensity <= r_lo) ? 8'd40 : 8'd255)
                                        : 8'd40 + r_q;
                    r_out.blue  <= r_ov ? ((r_in.intensity <= r_lo) ? 8'd40 : 8'd255)
                                        : 8'd40 + r_q;
                end
                default: begin
                    r_out.red <= pal_col[23:16];
                    r_out.green <= pal_col[15:8];
                    r_out.blue <= pal_col[7:0];
                end
            endcase
        end
    end
endmodule
`default_nettype wire
